// ----- hdl/pfss_pkg.sv -----
// pfss_pkg: shared types, codes and constants of the preamble framed serial sender
// no dependencies; compiled first

package pfss_pkg;

   // action codes of an input word
   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_START = 1'b1;

   // serial byte framing: start bit, eight data bits lsb first, stop bit
   localparam int unsigned BYTE_BITS = 10;
   localparam logic [3:0]  POS_START = 4'd0;
   localparam logic [3:0]  POS_STOP  = 4'd9;

   // status bytes of the second half of a frame
   localparam logic [7:0] STATUS_OFF = 8'd233;
   localparam logic [7:0] STATUS_ON  = 8'd255;

   // station address register
   localparam int unsigned ADDR_W = 2;

   typedef struct packed {
      logic line_bit;
      logic tx_enable;
      logic busy_res;
   } pfss_result_type;

   // preamble base: address with 1 and 2 swapped, then doubled
   function automatic logic [2:0] base_from_address(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] swapped;
      begin
         case (addr)
            2'd1: begin
               swapped = 2'd2;
            end
            2'd2: begin
               swapped = 2'd1;
            end
            default: begin
               swapped = addr;
            end
         endcase
         base_from_address = {swapped, 1'b0};
      end
   endfunction

endpackage

// ----- hdl/pfss_channels.sv -----
// pfss channels: valid/ready interfaces for request and response words
// depends on nothing; compiled after pfss_pkg

interface pfss_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] payload_byte;
   logic       timer_on;

   modport source (output valid, output action, output payload_byte, output timer_on,
                   input ready);
   modport sink   (input valid, input action, input payload_byte, input timer_on,
                   output ready);
endinterface

interface pfss_rsp_if;
   logic valid;
   logic ready;
   logic line_bit;
   logic tx_enable;
   logic busy_res;

   modport source (output valid, output line_bit, output tx_enable, output busy_res,
                   input ready);
   modport sink   (input valid, input line_bit, input tx_enable, input busy_res,
                   output ready);
endinterface

// ----- hdl/pfss_sequencer.sv -----
// pfss_sequencer: frame state and line bit selection for one word per accept
// depends on pfss_pkg

module pfss_sequencer
   import pfss_pkg::*;
#(
   parameter int unsigned IDLE_BITS      = 12,
   parameter int unsigned PREAMBLE_BYTES = 7,
   parameter int unsigned REPEATS        = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              action,
   input  logic [7:0]        payload_byte,
   input  logic              timer_on,
   input  logic [ADDR_W-1:0] station_address,
   output pfss_result_type   result
);

   localparam int unsigned BLOCKS  = 2 * REPEATS;
   localparam int unsigned BLOCK_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int unsigned IDLE_W  = $clog2(IDLE_BITS + 1);
   localparam int unsigned BIDX_W  = $clog2(PREAMBLE_BYTES + 1);
   localparam logic [BLOCK_W-1:0] LAST_BLOCK = BLOCK_W'(BLOCKS - 1);
   localparam logic [BLOCK_W-1:0] FIRST_STATUS_BLOCK = BLOCK_W'(REPEATS);
   localparam logic [IDLE_W-1:0]  LAST_IDLE = IDLE_W'(IDLE_BITS - 1);
   localparam logic [BIDX_W-1:0]  PAYLOAD_IDX = BIDX_W'(PREAMBLE_BYTES);

   logic               sending_ff, sending_in;
   logic [BLOCK_W-1:0] block_ff, block_in;
   logic               idle_phase_ff, idle_phase_in;
   logic [IDLE_W-1:0]  idle_cnt_ff, idle_cnt_in;
   logic [BIDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic [3:0]         pos_ff, pos_in;
   logic [7:0]         payload_ff, payload_in;
   logic               timer_ff, timer_in;
   logic [2:0]         base_ff, base_in;

   logic [7:0] cur_byte;
   logic [7:0] preamble_byte;
   logic [3:0] data_pos;
   logic       cur_bit;
   logic       frame_done;

   // byte on the line and its current bit
   always_comb begin
      preamble_byte = 8'(base_ff) + 8'(byte_idx_ff);
      if (byte_idx_ff != PAYLOAD_IDX) begin
         cur_byte = preamble_byte;
      end else if (block_ff < FIRST_STATUS_BLOCK) begin
         cur_byte = payload_ff;
      end else begin
         cur_byte = timer_ff ? STATUS_ON : STATUS_OFF;
      end
      data_pos = pos_ff - 4'd1;
      if (idle_phase_ff) begin
         cur_bit = 1'b1;
      end else if (pos_ff == POS_START) begin
         cur_bit = 1'b0;
      end else if (pos_ff == POS_STOP) begin
         cur_bit = 1'b1;
      end else begin
         cur_bit = cur_byte[data_pos[2:0]];
      end
   end

   // next state
   always_comb begin
      sending_in    = sending_ff;
      block_in      = block_ff;
      idle_phase_in = idle_phase_ff;
      idle_cnt_in   = idle_cnt_ff;
      byte_idx_in   = byte_idx_ff;
      pos_in        = pos_ff;
      payload_in    = payload_ff;
      timer_in      = timer_ff;
      base_in       = base_ff;
      frame_done    = 1'b0;
      if (action == ACTION_START) begin
         if (!sending_ff) begin
            sending_in    = 1'b1;
            block_in      = '0;
            idle_phase_in = 1'b1;
            idle_cnt_in   = '0;
            byte_idx_in   = '0;
            pos_in        = POS_START;
            payload_in    = payload_byte;
            timer_in      = timer_on;
            base_in       = base_from_address(station_address);
         end
      end else if (sending_ff) begin
         if (idle_phase_ff) begin
            if (idle_cnt_ff == LAST_IDLE) begin
               idle_phase_in = 1'b0;
               idle_cnt_in   = '0;
            end else begin
               idle_cnt_in = idle_cnt_ff + IDLE_W'(1);
            end
         end else if (pos_ff == POS_STOP) begin
            pos_in = POS_START;
            if (byte_idx_ff == PAYLOAD_IDX) begin
               byte_idx_in   = '0;
               idle_phase_in = 1'b1;
               if (block_ff == LAST_BLOCK) begin
                  block_in   = '0;
                  sending_in = 1'b0;
                  frame_done = 1'b1;
               end else begin
                  block_in = block_ff + BLOCK_W'(1);
               end
            end else begin
               byte_idx_in = byte_idx_ff + BIDX_W'(1);
            end
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   // result of this word
   always_comb begin
      if (action == ACTION_START) begin
         result.line_bit  = 1'b1;
         result.tx_enable = 1'b1;
         result.busy_res  = 1'b1;
      end else if (!sending_ff) begin
         result.line_bit  = 1'b1;
         result.tx_enable = 1'b0;
         result.busy_res  = 1'b0;
      end else begin
         result.line_bit  = cur_bit;
         result.tx_enable = 1'b1;
         result.busy_res  = !frame_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff    <= 1'b0;
         block_ff      <= '0;
         idle_phase_ff <= 1'b1;
         idle_cnt_ff   <= '0;
         byte_idx_ff   <= '0;
         pos_ff        <= POS_START;
         payload_ff    <= '0;
         timer_ff      <= 1'b0;
         base_ff       <= '0;
      end else if (step) begin
         sending_ff    <= sending_in;
         block_ff      <= block_in;
         idle_phase_ff <= idle_phase_in;
         idle_cnt_ff   <= idle_cnt_in;
         byte_idx_ff   <= byte_idx_in;
         pos_ff        <= pos_in;
         payload_ff    <= payload_in;
         timer_ff      <= timer_in;
         base_ff       <= base_in;
      end
   end

endmodule

// ----- hdl/preamble_framed_serial_sender_unit.sv -----
// preamble_framed_serial_sender_unit: top level of the preamble framed serial sender
// depends on pfss_pkg, pfss_channels (pfss_req_if, pfss_rsp_if) and pfss_sequencer

// Usage
//   req channel: one word per partner clock edge. action tick advances the frame by one
//   line bit; action start latches payload_byte and timer_on and begins a frame of
//   2*REPEATS blocks (IDLE_BITS ones, PREAMBLE_BYTES preamble bytes, one payload or
//   status byte). A start during a frame is ignored but still answered.
//   rsp channel: exactly one word back for every req word, in order: line_bit,
//   tx_enable and busy_res.
//   csr port: csr_write_enable/csr_write_data set the station address, which picks
//   the preamble base; it is sampled at the next start only.
//   rsp valid rises in the cycle after req accept, from the single output register
//   after the sequencer logic. One word per cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds its word and req_ready drops,
//   so the frame does not advance. Reset (synchronous, active high) empties the output
//   register, clears the station address and leaves the sender idle.

module preamble_framed_serial_sender_unit
   import pfss_pkg::*;
#(
   parameter int unsigned IDLE_BITS      = 12,
   parameter int unsigned PREAMBLE_BYTES = 7,
   parameter int unsigned REPEATS        = 2
) (
   input  logic              clock,
   input  logic              reset,
   pfss_req_if.sink          req,
   pfss_rsp_if.source        rsp,
   input  logic              csr_write_enable,
   input  logic [ADDR_W-1:0] csr_write_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   pfss_result_type   rsp_word_ff, rsp_word_in;
   logic [ADDR_W-1:0] station_addr_ff;
   logic              req_accept;

   // take a new word whenever the output register is empty or being drained
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   // station address register, used at the next frame start
   always_ff @(posedge clock) begin
      if (reset) begin
         station_addr_ff <= '0;
      end else if (csr_write_enable) begin
         station_addr_ff <= csr_write_data;
      end
   end

   // frame state and bit selection
   pfss_sequencer #(
      .IDLE_BITS      (IDLE_BITS),
      .PREAMBLE_BYTES (PREAMBLE_BYTES),
      .REPEATS        (REPEATS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .step            (req_accept),
      .action          (req.action),
      .payload_byte    (req.payload_byte),
      .timer_on        (req.timer_on),
      .station_address (station_addr_ff),
      .result          (rsp_word_in)
   );

   // output register valid tracking
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the output register, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.line_bit  = rsp_word_ff.line_bit;
   assign rsp.tx_enable = rsp_word_ff.tx_enable;
   assign rsp.busy_res  = rsp_word_ff.busy_res;

endmodule

// ----- tb/pfss_line_checker.sv -----
`timescale 1ns / 1ps
// pfss_line_checker: watches the req, rsp and csr ports of the serial sender,
// predicts every response word and compares it field by field
// depends on pfss_pkg and pfss_channels (pfss_req_if, pfss_rsp_if)

module pfss_line_checker
   import pfss_pkg::*;
#(
   parameter int unsigned IDLE_BITS      = 12,
   parameter int unsigned PREAMBLE_BYTES = 7,
   parameter int unsigned REPEATS        = 2
) (
   input  logic              clock,
   input  logic              reset,
   pfss_req_if               req_mon,
   pfss_rsp_if               rsp_mon,
   input  logic              csr_write_enable,
   input  logic [ADDR_W-1:0] csr_write_data,
   output int unsigned       mismatch_count
);

   localparam int unsigned BLOCK_BITS  = IDLE_BITS + (PREAMBLE_BYTES + 1) * BYTE_BITS;
   localparam int unsigned FRAME_BLOCKS = 2 * REPEATS;

   // shadow of the sender
   logic              sending;
   int unsigned       block_idx;
   int unsigned       bit_pos;
   logic [7:0]        held_byte;
   logic              held_timer;
   logic [7:0]        base;
   logic [ADDR_W-1:0] station;

   pfss_result_type line_words_due[$];

   initial mismatch_count = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // addresses 1 and 2 trade places, then the value is doubled
   function automatic logic [7:0] base_for_station(input logic [ADDR_W-1:0] addr);
      case (addr)
         2'd1: begin
            return 8'd4;
         end
         2'd2: begin
            return 8'd2;
         end
         default: begin
            return {5'd0, addr, 1'b0};
         end
      endcase
   endfunction

   function automatic logic frame_bit();
      int unsigned offset;
      int unsigned byte_idx;
      int unsigned pos;
      logic [7:0]  data_byte;
      if (bit_pos < IDLE_BITS) return 1'b1;
      offset   = bit_pos - IDLE_BITS;
      byte_idx = offset / BYTE_BITS;
      pos      = offset % BYTE_BITS;
      if (byte_idx < PREAMBLE_BYTES) data_byte = 8'(base + byte_idx);
      else if (block_idx < REPEATS) data_byte = held_byte;
      else data_byte = held_timer ? STATUS_ON : STATUS_OFF;
      if (pos == POS_START) return 1'b0;
      if (pos == POS_STOP) return 1'b1;
      return data_byte[pos - 1];
   endfunction

   // next response word for one accepted request word, moves the shadow on
   function automatic pfss_result_type next_line_word(input logic act,
                                                      input logic [7:0] pay,
                                                      input logic tmr);
      logic line;
      if (act == ACTION_START) begin
         if (!sending) begin
            sending    = 1'b1;
            block_idx  = 0;
            bit_pos    = 0;
            held_byte  = pay;
            held_timer = tmr;
            base       = base_for_station(station);
         end
         return '{line_bit: 1'b1, tx_enable: 1'b1, busy_res: 1'b1};
      end
      if (!sending) return '{line_bit: 1'b1, tx_enable: 1'b0, busy_res: 1'b0};
      line = frame_bit();
      bit_pos++;
      if (bit_pos >= BLOCK_BITS) begin
         bit_pos = 0;
         block_idx++;
         if (block_idx >= FRAME_BLOCKS) begin
            block_idx = 0;
            sending   = 1'b0;
         end
      end
      return '{line_bit: line, tx_enable: 1'b1, busy_res: sending};
   endfunction

   always @(posedge clock) begin
      pfss_result_type want;
      pfss_result_type got;
      if (reset) begin
         sending    = 1'b0;
         block_idx  = 0;
         bit_pos    = 0;
         held_byte  = 8'd0;
         held_timer = 1'b0;
         base       = 8'd0;
         station    = '0;
         line_words_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{line_bit: rsp_mon.line_bit, tx_enable: rsp_mon.tx_enable,
                    busy_res: rsp_mon.busy_res};
            if (line_words_due.size() == 0) begin
               report_mismatch("response word with none expected");
            end else begin
               want = line_words_due.pop_front();
               if (got.line_bit !== want.line_bit)
                  report_mismatch($sformatf("line_bit %b, expected %b",
                                            got.line_bit, want.line_bit));
               if (got.tx_enable !== want.tx_enable)
                  report_mismatch($sformatf("tx_enable %b, expected %b",
                                            got.tx_enable, want.tx_enable));
               if (got.busy_res !== want.busy_res)
                  report_mismatch($sformatf("busy_res %b, expected %b",
                                            got.busy_res, want.busy_res));
            end
         end
         if (req_mon.valid && req_mon.ready)
            line_words_due.push_back(next_line_word(req_mon.action, req_mon.payload_byte,
                                                    req_mon.timer_on));
         if (csr_write_enable) station = csr_write_data;
      end
   end

endmodule

// ----- tb/preamble_framed_serial_sender_unit_tb.sv -----
`timescale 1ns / 1ps
// preamble_framed_serial_sender_unit_tb: stimulus and verdict for the serial sender
// depends on pfss_pkg, pfss_channels, preamble_framed_serial_sender_unit, pfss_line_checker

module preamble_framed_serial_sender_unit_tb;
   import pfss_pkg::*;

   localparam int unsigned IDLE_BITS      = 12;
   localparam int unsigned PREAMBLE_BYTES = 7;
   localparam int unsigned REPEATS        = 2;

   // ticks that carry one whole frame from start to last stop bit
   localparam int unsigned FRAME_TICKS =
      2 * REPEATS * (IDLE_BITS + (PREAMBLE_BYTES + 1) * BYTE_BITS);
   // last frame is cut short partway into block 1, once block 0 preamble and payload are out
   localparam int unsigned SHORT_TICKS = 130;

   // rate phase moves on after PHASE_WORDS and 2*PHASE_WORDS accepted request words
   localparam int unsigned PHASE_WORDS = 420;
   // long receiver hold-off, starts once HOLD_AT words went in
   localparam int unsigned HOLD_AT     = 300;
   localparam int unsigned HOLD_CYCLES = 150;
   // cycles without any handshake before the run is called dead
   localparam int unsigned QUIET_LIMIT = 2000;

   typedef enum logic [1:0] {
      SINK_SLOW,     // sender gaps 24 of 100, receiver stalls 68 of 100
      SOURCE_SLOW,   // the other way round
      FULL_RATE      // no gaps, no stalls
   } rate_phase_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [ADDR_W-1:0] csr_write_data;
   int unsigned       mismatches;

   // handshake bookkeeping, also feeds the watchdog
   int unsigned req_count   = 0;
   int unsigned rsp_count   = 0;
   int unsigned quiet_count = 0;

   pfss_req_if req_ch ();
   pfss_rsp_if rsp_ch ();

   preamble_framed_serial_sender_unit #(
      .IDLE_BITS      (IDLE_BITS),
      .PREAMBLE_BYTES (PREAMBLE_BYTES),
      .REPEATS        (REPEATS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   pfss_line_checker #(
      .IDLE_BITS      (IDLE_BITS),
      .PREAMBLE_BYTES (PREAMBLE_BYTES),
      .REPEATS        (REPEATS)
   ) line_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rate_phase_type rate_phase();
      if (req_count < PHASE_WORDS) return SINK_SLOW;
      if (req_count < 2 * PHASE_WORDS) return SOURCE_SLOW;
      return FULL_RATE;
   endfunction

   // count accepted words on both sides; the watchdog trips when neither moves
   always @(posedge clock) begin
      if (reset) begin
         req_count   <= 0;
         rsp_count   <= 0;
         quiet_count <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) req_count <= req_count + 1;
         if (rsp_ch.valid && rsp_ch.ready) rsp_count <= rsp_count + 1;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_count <= 0;
         end else if (quiet_count >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end else begin
            quiet_count <= quiet_count + 1;
         end
      end
   end

   // receiver side: random stalls per phase, plus one long hold-off so the
   // output register fills and req_ready drops while the sender keeps offering
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && req_count >= HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         case (rate_phase())
            SINK_SLOW: begin
               rsp_ch.ready <= ($urandom_range(99) >= 68);
            end
            SOURCE_SLOW: begin
               rsp_ch.ready <= ($urandom_range(99) >= 24);
            end
            default: begin
               rsp_ch.ready <= 1'b1;
            end
         endcase
      end
   end

   // offer one request word, with random gaps ahead of it; returns at the
   // rising edge where it was accepted, valid still high
   task automatic put_word(input logic act, input logic [7:0] pay, input logic tmr);
      int unsigned gap_pct;
      @(negedge clock);
      gap_pct = (rate_phase() == SINK_SLOW)   ? 24 :
                (rate_phase() == SOURCE_SLOW) ? 68 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.payload_byte <= pay;
      req_ch.timer_on     <= tmr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // station address write, only once every response word is back
   task automatic set_station(input logic [ADDR_W-1:0] addr);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (rsp_count != req_count) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= addr;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // a run of frame ticks with now and then a start that lands mid-frame
   // and must be ignored; the stray starts do not count as ticks
   task automatic tick_run(input int unsigned ticks);
      int unsigned done;
      done = 0;
      while (done < ticks) begin
         if ($urandom_range(99) < 3) begin
            put_word(ACTION_START, 8'($urandom), 1'($urandom));
         end else begin
            put_word(ACTION_TICK, 8'($urandom), 1'($urandom));
            done++;
         end
      end
   endtask

   // start a frame, give it the given ticks, then up to three more ticks (sometimes none, so
   // the next start follows the last stop bit directly)
   task automatic run_frame(input logic [7:0] pay, input logic tmr,
                            input int unsigned ticks);
      put_word(ACTION_START, pay, tmr);
      tick_run(ticks);
      repeat ($urandom_range(3)) put_word(ACTION_TICK, 8'($urandom), 1'($urandom));
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACTION_TICK;
      req_ch.payload_byte = 8'd0;
      req_ch.timer_on     = 1'b0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lowest station address, written even though it is the reset value
      set_station(2'd0);

      // ticks while idle: line high, transmitter off
      put_word(ACTION_TICK, 8'hFF, 1'b1);
      put_word(ACTION_TICK, 8'h00, 1'b0);
      put_word(ACTION_TICK, 8'hA5, 1'b1);
      // all-zero payload with timer clear, then an all-ones start that must
      // be ignored while the frame is under way
      put_word(ACTION_START, 8'h00, 1'b0);
      put_word(ACTION_START, 8'hFF, 1'b1);
      repeat (20) put_word(ACTION_TICK, 8'($urandom), 1'($urandom));

      // address change mid-frame: this frame keeps preamble base 0,
      // the next start picks up base 6
      set_station(2'd3);
      tick_run(FRAME_TICKS - 20);
      put_word(ACTION_TICK, 8'h5A, 1'b0);
      put_word(ACTION_TICK, 8'hC3, 1'b1);

      // all-ones payload, timer set: status byte 255 in the second half
      run_frame(8'hFF, 1'b1, FRAME_TICKS);

      set_station(2'd1);
      run_frame(8'($urandom), 1'($urandom), FRAME_TICKS);

      set_station(2'd2);
      run_frame(8'($urandom), 1'($urandom), SHORT_TICKS);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (rsp_count != req_count) @(negedge clock);
      // wait on to catch any stray response word
      repeat (4) @(negedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
